>>> sv/swfe_pkg.sv
package swfe_pkg;

  // Default geometry of a frame.
  localparam int unsigned SyncLenDef       = 8;
  localparam int unsigned TimeBytesDef     = 4;
  localparam int unsigned MaxValuesDef     = 16;
  localparam int unsigned MaxValueBytesDef = 8;

  // Configuration register layout.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_PATTERN     = 2'd0,
    CFG_BYTES_PER_VALUE  = 2'd1,
    CFG_VALUES_PER_FRAME = 2'd2
  } cfg_idx_e;

  localparam logic [3:0] BytesPerValueRst  = 4'd4;
  localparam logic [4:0] ValuesPerFrameRst = 5'd1;

  // Depth of the queue between the parser and the output stage.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [31:0] seconds;
    logic [31:0] microseconds;
    logic [31:0] value;
    logic [3:0]  value_index;
    logic        last_in_frame;
  } result_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Byte idx of a little-endian word is replaced. Writing byte 0 starts a
  // fresh word, so the upper bytes are cleared; bytes past 3 are dropped.
  function automatic logic [31:0] put_byte(input logic [31:0] word,
                                           input logic [3:0]  idx,
                                           input logic [7:0]  b);
    logic [31:0] res;
    res = word;
    case (idx)
      4'd0:    res = {24'b0, b};
      4'd1:    res[15:8]  = b;
      4'd2:    res[23:16] = b;
      4'd3:    res[31:24] = b;
      default: res = word;
    endcase
    return res;
  endfunction

  function automatic logic [7:0] sync_byte(input logic [CfgDataW-1:0] pattern,
                                           input logic [2:0]          idx);
    return pattern[idx*8 +: 8];
  endfunction

endpackage

>>> sv/sync_word_frame_extractor.sv
// Channel   Direction  Handshake               Payload
// config    in         cfg_we_i                cfg_index_i, cfg_data_i
// input     in         in_valid_i/in_ready_o   data_byte_i
// result    out        out_valid_o/out_ready_i seconds_o, microseconds_o, value_o,
//                                              value_index_o, last_in_frame_o
//
// One byte is taken per cycle while in_ready_o is high; the parser updates its
// counters in the cycle of acceptance, so an item causes no stall of its own.
// A result enters a two-entry queue when its last byte is accepted and then moves
// into the output register, which drives out_valid_o.
// in_ready_o drops only while the queue is full, which needs the output side to hold.
// Reset is asynchronous and active low; the parser returns to sync hunting.
module sync_word_frame_extractor #(
  parameter int unsigned SYNC_LEN        = swfe_pkg::SyncLenDef,
  parameter int unsigned TIME_BYTES      = swfe_pkg::TimeBytesDef,
  parameter int unsigned MAX_VALUES      = swfe_pkg::MaxValuesDef,
  parameter int unsigned MAX_VALUE_BYTES = swfe_pkg::MaxValueBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swfe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [swfe_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   seconds_o,
  output logic [31:0]                   microseconds_o,
  output logic [31:0]                   value_o,
  output logic [3:0]                    value_index_o,
  output logic                          last_in_frame_o
);

  logic                    accept;
  logic                    push;
  logic                    pop;
  swfe_pkg::result_t       result;
  swfe_pkg::result_t       head;
  swfe_pkg::result_t       out_data;
  swfe_pkg::queue_status_t q_status;

  assign in_ready_o = !q_status.full;
  assign accept     = in_valid_i && in_ready_o;

  swfe_front #(
    .SYNC_LEN        (SYNC_LEN),
    .TIME_BYTES      (TIME_BYTES),
    .MAX_VALUES      (MAX_VALUES),
    .MAX_VALUE_BYTES (MAX_VALUE_BYTES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .push_o      (push),
    .result_o    (result)
  );

  swfe_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (result),
    .pop_i    (pop),
    .data_o   (head),
    .status_o (q_status)
  );

  swfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .status_i    (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_data)
  );

  assign seconds_o       = out_data.seconds;
  assign microseconds_o  = out_data.microseconds;
  assign value_o         = out_data.value;
  assign value_index_o   = out_data.value_index;
  assign last_in_frame_o = out_data.last_in_frame;

endmodule

>>> sv/swfe_front.sv
module swfe_front #(
  parameter int unsigned SYNC_LEN        = swfe_pkg::SyncLenDef,
  parameter int unsigned TIME_BYTES      = swfe_pkg::TimeBytesDef,
  parameter int unsigned MAX_VALUES      = swfe_pkg::MaxValuesDef,
  parameter int unsigned MAX_VALUE_BYTES = swfe_pkg::MaxValueBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [swfe_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [swfe_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          accept_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          push_o,
  output swfe_pkg::result_t             result_o
);

  localparam int unsigned TsStart = SYNC_LEN;
  localparam int unsigned UsStart = SYNC_LEN + TIME_BYTES;
  localparam int unsigned DataPos = SYNC_LEN + 2 * TIME_BYTES;
  localparam int unsigned PosW    = $clog2(DataPos + 1);
  localparam int unsigned VcntW   = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;

  logic [swfe_pkg::CfgDataW-1:0] sync_q;
  logic [3:0]                    bpv_q;
  logic [4:0]                    vpf_q;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [2:0]       biv_q, biv_d;
  logic [VcntW-1:0] vcnt_q, vcnt_d;
  logic [31:0]      sec_q, sec_d;
  logic [31:0]      usec_q, usec_d;
  logic [31:0]      acc_q, acc_d;

  logic [7:0]      pos8;
  logic [PosW-1:0] ts_off, us_off;
  logic [3:0]      bpv_eff;
  logic [6:0]      vpf_eff;
  logic [6:0]      vcnt7;
  logic            value_done;
  logic            frame_last;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q <= '0;
      bpv_q  <= swfe_pkg::BytesPerValueRst;
      vpf_q  <= swfe_pkg::ValuesPerFrameRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        swfe_pkg::CFG_SYNC_PATTERN:     sync_q <= cfg_data_i;
        swfe_pkg::CFG_BYTES_PER_VALUE:  bpv_q  <= cfg_data_i[3:0];
        swfe_pkg::CFG_VALUES_PER_FRAME: vpf_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (bpv_q == 4'd0) begin
      bpv_eff = 4'd1;
    end else if (bpv_q > 4'(MAX_VALUE_BYTES)) begin
      bpv_eff = 4'(MAX_VALUE_BYTES);
    end else begin
      bpv_eff = bpv_q;
    end
    if (vpf_q == 5'd0) begin
      vpf_eff = 7'd1;
    end else if (7'(vpf_q) > 7'(MAX_VALUES)) begin
      vpf_eff = 7'(MAX_VALUES);
    end else begin
      vpf_eff = 7'(vpf_q);
    end
  end

  assign pos8       = 8'(pos_q);
  assign ts_off     = pos_q - PosW'(TsStart);
  assign us_off     = pos_q - PosW'(UsStart);
  assign vcnt7      = 7'(vcnt_q);
  assign acc_d      = swfe_pkg::put_byte(acc_q, {1'b0, biv_q}, data_byte_i);
  assign value_done = ({1'b0, biv_q} + 4'd1) >= bpv_eff;
  assign frame_last = (vcnt7 + 7'd1) >= vpf_eff;

  always_comb begin
    pos_d  = pos_q;
    biv_d  = biv_q;
    vcnt_d = vcnt_q;
    sec_d  = sec_q;
    usec_d = usec_q;
    push_o = 1'b0;
    if (accept_i) begin
      if (pos_q < PosW'(TsStart)) begin
        // Hunting: a mismatching byte may still open a new attempt.
        if (data_byte_i == swfe_pkg::sync_byte(sync_q, pos8[2:0])) begin
          pos_d = pos_q + PosW'(1);
        end else if (data_byte_i == swfe_pkg::sync_byte(sync_q, 3'd0)) begin
          pos_d = PosW'(1);
        end else begin
          pos_d = '0;
        end
      end else if (pos_q < PosW'(UsStart)) begin
        sec_d = swfe_pkg::put_byte(sec_q, 4'(ts_off[1:0]), data_byte_i);
        pos_d = pos_q + PosW'(1);
      end else if (pos_q < PosW'(DataPos)) begin
        usec_d = swfe_pkg::put_byte(usec_q, 4'(us_off[1:0]), data_byte_i);
        pos_d  = pos_q + PosW'(1);
        if (pos_q == PosW'(DataPos - 1)) begin
          biv_d  = '0;
          vcnt_d = '0;
        end
      end else if (!value_done) begin
        biv_d = biv_q + 3'd1;
      end else begin
        push_o = 1'b1;
        biv_d  = '0;
        if (frame_last) begin
          vcnt_d = '0;
          pos_d  = '0;
        end else begin
          vcnt_d = vcnt_q + VcntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      biv_q  <= '0;
      vcnt_q <= '0;
    end else begin
      pos_q  <= pos_d;
      biv_q  <= biv_d;
      vcnt_q <= vcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sec_q  <= sec_d;
    usec_q <= usec_d;
    if (accept_i && pos_q >= PosW'(DataPos)) begin
      acc_q <= acc_d;
    end
  end

  assign result_o.seconds       = sec_q;
  assign result_o.microseconds  = usec_q;
  assign result_o.value         = acc_d;
  assign result_o.value_index   = vcnt7[3:0];
  assign result_o.last_in_frame = frame_last;

endmodule

>>> sv/swfe_queue.sv
module swfe_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  swfe_pkg::result_t       data_i,
  input  logic                    pop_i,
  output swfe_pkg::result_t       data_o,
  output swfe_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = swfe_pkg::QueuePtrW;
  localparam int unsigned CntW = swfe_pkg::QueueCntW;

  swfe_pkg::result_t mem_q [swfe_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(swfe_pkg::QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == CntW'(swfe_pkg::QueueDepth));
  assign status_o.empty = (cnt_q == '0);

endmodule

>>> sv/swfe_back.sv
module swfe_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  swfe_pkg::result_t       head_i,
  input  swfe_pkg::queue_status_t status_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output swfe_pkg::result_t       out_o
);

  logic              valid_q;
  swfe_pkg::result_t data_q;

  // The output register refills whenever it is empty or being drained.
  assign pop_o = !status_i.empty && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || out_ready_i) begin
      valid_q <= !status_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= head_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

>>> sv/swfe_checker.sv
module swfe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] value_o,
  input logic [3:0]  value_index_o,
  input logic        last_in_frame_o
);

  // A held result keeps its value, index and last-in-frame flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) &&
      $stable(value_index_o) && $stable(last_in_frame_o))
    else $error("result changed while stalled");

  // The input side can only be blocked when results are piling up at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // Reset empties the output stage.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result visible during reset");

  // A blocked input is released only by a result leaving the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> $past(out_valid_o && out_ready_i))
    else $error("input released without a drained result");

endmodule

bind sync_word_frame_extractor swfe_checker u_swfe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .value_o         (value_o),
  .value_index_o   (value_index_o),
  .last_in_frame_o (last_in_frame_o)
);
